// ----- rtl/strongest_contributor_table_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Strongest contributor table assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STRONGEST_CONTRIBUTOR_TABLE_UNIT_MACROS_SVH
`define STRONGEST_CONTRIBUTOR_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define SCT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sct_pkg.sv -----
// ----------------------------------------------------------------------------
// Strongest contributor table package
// Operation codes, fixed field widths and controller command bundle.
// ----------------------------------------------------------------------------
package sct_pkg;

	localparam int OP_W    = 3;
	localparam int ID_W    = 16;
	localparam int INFL_W  = 16;
	localparam int TIME_W  = 32;
	localparam int IDX_W   = 3;
	localparam int MASK_W  = 8;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_CLR_ACTIVE  = 3'd0,
		OP_ADD         = 3'd1,
		OP_DELETE      = 3'd2,
		OP_MARK        = 3'd3,
		OP_CLR_CHANGED = 3'd4,
		OP_READ        = 3'd5
	} op_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
	} sct_cmd_t;

endpackage

// ----- rtl/sct_ctrl.sv -----
// ----------------------------------------------------------------------------
// Strongest contributor table controller
// Sequences capture, table update and result delivery for one transaction.
// ----------------------------------------------------------------------------
`include "strongest_contributor_table_unit_macros.svh"

module sct_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output sct_pkg::sct_cmd_t cmd
);
	import sct_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (out_ready) state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// handshakes and commands
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);
	assign cmd.load  = in_valid && in_ready;
	assign cmd.exec  = (state_q == S_EXEC);

	`SCT_ASSERT_IMPL(a_ready_excl, in_ready, !out_valid, "input ready while result pending")
	`SCT_ASSERT_NEXT(a_load_exec, cmd.load, cmd.exec, "captured transaction not executed")
	`SCT_ASSERT_NEXT(a_exec_out, cmd.exec, out_valid, "executed transaction not presented")

endmodule

// ----- rtl/sct_dp.sv -----
// ----------------------------------------------------------------------------
// Strongest contributor table datapath
// Slot table, masks, deletion time, slot searches and result registers.
// ----------------------------------------------------------------------------
`include "strongest_contributor_table_unit_macros.svh"

module sct_dp #(
	parameter int SLOT_COUNT = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sct_pkg::sct_cmd_t         cmd,
	input  logic                      cfg_we,
	input  logic [sct_pkg::INFL_W-1:0] cfg_data,
	input  logic [sct_pkg::OP_W-1:0]   op,
	input  logic [sct_pkg::ID_W-1:0]   source_id,
	input  logic [sct_pkg::INFL_W-1:0] intensity,
	input  logic [sct_pkg::TIME_W-1:0] now_ms,
	input  logic [sct_pkg::IDX_W-1:0]  slot_index,
	output logic [sct_pkg::MASK_W-1:0] active_mask,
	output logic [sct_pkg::MASK_W-1:0] changed_mask,
	output logic                      accepted,
	output logic [sct_pkg::IDX_W-1:0]  slot_used,
	output logic [sct_pkg::ID_W-1:0]   read_source,
	output logic                      read_valid,
	output logic [sct_pkg::TIME_W-1:0] last_deletion_ms
);
	import sct_pkg::*;

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	// captured transaction
	logic [OP_W-1:0]   op_q;
	logic [ID_W-1:0]   id_q;
	logic [INFL_W-1:0] inten_q;
	logic [TIME_W-1:0] now_q;
	logic [IDX_W-1:0]  idx_q;

	// table state
	logic [INFL_W-1:0] min_q;
	logic [ID_W-1:0]   src_q  [SLOT_COUNT];
	logic [INFL_W-1:0] infl_q [SLOT_COUNT];
	logic [MASK_W-1:0] active_q;
	logic [MASK_W-1:0] changed_q;
	logic [TIME_W-1:0] del_q;

	// result registers
	logic              accepted_q;
	logic [IDX_W-1:0]  used_q;
	logic [ID_W-1:0]   rd_src_q;
	logic              rd_valid_q;

	// search results
	logic              hit_found;
	logic [SLOT_W-1:0] hit_idx;
	logic [INFL_W-1:0] hit_infl;
	logic              empty_found;
	logic [SLOT_W-1:0] empty_idx;
	logic [SLOT_W-1:0] weak_idx;
	logic [INFL_W-1:0] weak_infl;
	logic              add_ok;
	logic              place;
	logic              same_entry;
	logic [SLOT_W-1:0] sel_idx;
	logic [MASK_W-1:0] sel_oh;
	logic [MASK_W-1:0] hit_oh;
	logic [ID_W-1:0]   rd_src;
	logic              rd_act;

	// capture input transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			id_q    <= source_id;
			inten_q <= intensity;
			now_q   <= now_ms;
			idx_q   <= slot_index;
		end
	end

	// first slot holding the id
	always_comb begin
		hit_found = 1'b0;
		hit_idx   = '0;
		hit_infl  = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (!hit_found && (id_q != '0) && (src_q[i] == id_q)) begin
				hit_found = 1'b1;
				hit_idx   = SLOT_W'(i);
				hit_infl  = infl_q[i];
			end
		end
	end

	// first empty slot
	always_comb begin
		empty_found = 1'b0;
		empty_idx   = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (!empty_found && (src_q[i] == '0)) begin
				empty_found = 1'b1;
				empty_idx   = SLOT_W'(i);
			end
		end
	end

	// weakest slot, lowest index on a tie
	always_comb begin
		weak_idx  = '0;
		weak_infl = infl_q[0];
		for (int i = 1; i < SLOT_COUNT; i++) begin
			if (infl_q[i] < weak_infl) begin
				weak_idx  = SLOT_W'(i);
				weak_infl = infl_q[i];
			end
		end
	end

	// add slot choice
	always_comb begin
		add_ok     = (id_q != '0) && (inten_q >= min_q);
		place      = 1'b0;
		sel_idx    = weak_idx;
		same_entry = hit_found && (hit_infl == inten_q);
		if (hit_found) begin
			place   = add_ok;
			sel_idx = hit_idx;
		end else if (empty_found) begin
			place   = add_ok;
			sel_idx = empty_idx;
		end else if (inten_q > weak_infl) begin
			place   = add_ok;
			sel_idx = weak_idx;
		end
	end

	assign sel_oh = MASK_W'(1) << sel_idx;
	assign hit_oh = MASK_W'(1) << hit_idx;

	// slot read, out-of-range index matches no slot
	always_comb begin
		rd_src = '0;
		rd_act = 1'b0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (idx_q == IDX_W'(i)) begin
				rd_src = src_q[i];
				rd_act = active_q[i];
			end
		end
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= INFL_W'(13);
		end else if (cfg_we) begin
			min_q <= cfg_data;
		end
	end

	// table update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				src_q[i]  <= '0;
				infl_q[i] <= '0;
			end
			active_q  <= '0;
			changed_q <= '0;
			del_q     <= '0;
		end else if (cmd.exec) begin
			case (op_q)
				OP_CLR_ACTIVE: begin
					active_q <= '0;
				end
				OP_ADD: begin
					if (place) begin
						src_q[sel_idx]  <= id_q;
						infl_q[sel_idx] <= inten_q;
						active_q        <= active_q | sel_oh;
						if (!same_entry) changed_q <= changed_q | sel_oh;
					end
				end
				OP_DELETE: begin
					if (hit_found) begin
						src_q[hit_idx] <= '0;
						active_q       <= active_q & ~hit_oh;
						changed_q      <= changed_q | hit_oh;
						del_q          <= now_q;
					end
				end
				OP_MARK: begin
					if (hit_found) changed_q <= changed_q | hit_oh;
				end
				OP_CLR_CHANGED: begin
					changed_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			accepted_q <= 1'b0;
			used_q     <= '0;
			rd_src_q   <= '0;
			rd_valid_q <= 1'b0;
			case (op_q)
				OP_ADD: begin
					if (place) begin
						accepted_q <= 1'b1;
						used_q     <= IDX_W'(sel_idx);
					end
				end
				OP_DELETE, OP_MARK: begin
					if (hit_found) used_q <= IDX_W'(hit_idx);
				end
				OP_READ: begin
					if (rd_act) begin
						rd_valid_q <= 1'b1;
						rd_src_q   <= rd_src;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign active_mask      = active_q;
	assign changed_mask     = changed_q;
	assign accepted         = accepted_q;
	assign slot_used        = used_q;
	assign read_source      = rd_src_q;
	assign read_valid       = rd_valid_q;
	assign last_deletion_ms = del_q;

	`SCT_ASSERT_IMPL(a_mask_range, 1'b1, ((active_q | changed_q) >> SLOT_COUNT) == '0, "mask bit beyond table")
	`SCT_ASSERT_NEXT(a_acc_add, cmd.exec && (op_q != OP_ADD), !accepted_q, "accepted set on non-add")
	`SCT_ASSERT_NEXT(a_del_clear, cmd.exec && (op_q == OP_DELETE) && hit_found, (active_q & $past(hit_oh)) == '0, "deleted slot still active")

endmodule

// ----- rtl/strongest_contributor_table_unit.sv -----
// Strongest contributor table unit
// Input channel (in_valid/in_ready) carries op, source_id, intensity, now_ms
// and slot_index; each transaction yields exactly one result on the output
// channel (out_valid/out_ready) with the masks, add status, slot, read data
// and last deletion time as they stand after the operation.
// The config channel (cfg_valid/cfg_ready) writes the add floor, an unsigned
// Q8.8 value below which adds are ignored; it is always ready and should be
// used only while idle.
// After the input transaction is taken, the controller passes through the
// execute state to the done state, where the result is presented.
// The slot table is searched and updated in the execute state, and the
// controller holds one transaction from capture until its result is taken,
// so no new transaction is accepted while one is held.
// A stalled receiver holds the result stable and blocks new input until it
// is taken.
// Reset clears the table, both masks and the deletion time and sets the add
// floor to raw code 13 (13/256); the unit is ready for input right after reset.
// ----------------------------------------------------------------------------
// Strongest contributor table unit top level
// Joins the controller and the table datapath.
// ----------------------------------------------------------------------------
module strongest_contributor_table_unit #(
	parameter int SLOT_COUNT = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [sct_pkg::INFL_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [sct_pkg::OP_W-1:0]   op,
	input  logic [sct_pkg::ID_W-1:0]   source_id,
	input  logic [sct_pkg::INFL_W-1:0] intensity,
	input  logic [sct_pkg::TIME_W-1:0] now_ms,
	input  logic [sct_pkg::IDX_W-1:0]  slot_index,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [sct_pkg::MASK_W-1:0] active_mask,
	output logic [sct_pkg::MASK_W-1:0] changed_mask,
	output logic                       accepted,
	output logic [sct_pkg::IDX_W-1:0]  slot_used,
	output logic [sct_pkg::ID_W-1:0]   read_source,
	output logic                       read_valid,
	output logic [sct_pkg::TIME_W-1:0] last_deletion_ms
);
	import sct_pkg::*;

	sct_cmd_t cmd;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	// controller
	sct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// datapath
	sct_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_data         (cfg_data),
		.op               (op),
		.source_id        (source_id),
		.intensity        (intensity),
		.now_ms           (now_ms),
		.slot_index       (slot_index),
		.active_mask      (active_mask),
		.changed_mask     (changed_mask),
		.accepted         (accepted),
		.slot_used        (slot_used),
		.read_source      (read_source),
		.read_valid       (read_valid),
		.last_deletion_ms (last_deletion_ms)
	);

endmodule
